@@ design/lnef_pkg.sv @@
// Package for the line nth extremum finder.
// Holds configuration and status types, register indexes, mode codes and fixed widths.
// No dependencies.
`default_nettype none
package lnef_pkg;

  localparam int LINE_LEN_DEF    = 1024;
  localparam int HIT_DEPTH_DEF   = 512;
  localparam int MEAN_MARGIN_DEF = 15;
  localparam int MIN_MEAN_COUNT  = 5;

  localparam int VAL_W  = 32;
  localparam int RANK_W = 8;
  localparam int X_W    = 10;
  localparam int DEN_W  = 10;
  localparam int SUM_W  = 41;
  localparam int PROD_W = 42;
  localparam int NUM_W  = 43;
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 32;

  localparam logic [CIDX_W-1:0] REG_SEARCH_MODE    = 3'd0;
  localparam logic [CIDX_W-1:0] REG_FROM_RIGHT     = 3'd1;
  localparam logic [CIDX_W-1:0] REG_WANTED_NUMBER  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_LEVEL          = 3'd3;
  localparam logic [CIDX_W-1:0] REG_SLOPE_DISTANCE = 3'd4;
  localparam logic [CIDX_W-1:0] REG_BAND           = 3'd5;
  localparam logic [CIDX_W-1:0] REG_USE_MEAN       = 3'd6;

  localparam logic [1:0] MODE_MIN   = 2'd0;
  localparam logic [1:0] MODE_MAX   = 2'd1;
  localparam logic [1:0] MODE_CROSS = 2'd2;

  typedef struct packed {
    logic [1:0]               search_mode;
    logic                     from_right;
    logic [7:0]               wanted_number;
    logic signed [VAL_W-1:0]  level;
    logic [8:0]               slope_distance;
    logic signed [VAL_W-1:0]  band;
    logic                     use_mean;
  } cfg_t;

  typedef struct packed {
    logic searching;
    logic line_full;
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_CR, S_MF, S_MS, S_MUL, S_NUM,
    S_SV, S_SP, S_SE, S_SEL, S_HW, S_FETCH, S_OUT
  } state_t;

endpackage
`default_nettype wire

@@ design/lnef_if.sv @@
// Channel interfaces: sample input, result output and configuration write.
// Depends on lnef_pkg for field widths.
`default_nettype none
interface lnef_sample_if;
  logic                             valid;
  logic                             ready;
  logic signed [lnef_pkg::VAL_W-1:0] sample_value;
  logic [lnef_pkg::RANK_W-1:0]      sample_rank;
  logic                             line_end;
  modport source (output valid, sample_value, sample_rank, line_end, input ready);
  modport sink (input valid, sample_value, sample_rank, line_end, output ready);
endinterface

interface lnef_result_if;
  logic                             valid;
  logic                             ready;
  logic [lnef_pkg::X_W-1:0]         found_x;
  logic signed [lnef_pkg::VAL_W-1:0] found_value;
  logic [lnef_pkg::RANK_W-1:0]      found_rank;
  modport source (output valid, found_x, found_value, found_rank, input ready);
  modport sink (input valid, found_x, found_value, found_rank, output ready);
endinterface

interface lnef_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [lnef_pkg::CIDX_W-1:0] index;
  logic [lnef_pkg::CDAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/lnef_ram.sv @@
// Generic single write port RAM with one registered read port.
// No dependencies.
`default_nettype none
module lnef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ design/lnef_cfg_regs.sv @@
// Configuration register file, written through the configuration channel.
// Depends on lnef_pkg and lnef_if.
`default_nettype none
module lnef_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  lnef_cfg_if.sink           cfg,
  output lnef_pkg::cfg_t     regs
);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.search_mode    <= lnef_pkg::MODE_MAX;
      regs.from_right     <= 1'b0;
      regs.wanted_number  <= 8'd1;
      regs.level          <= '0;
      regs.slope_distance <= 9'd1;
      regs.band           <= '0;
      regs.use_mean       <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.index)
        lnef_pkg::REG_SEARCH_MODE:    regs.search_mode    <= cfg.data[1:0];
        lnef_pkg::REG_FROM_RIGHT:     regs.from_right     <= cfg.data[0];
        lnef_pkg::REG_WANTED_NUMBER:  regs.wanted_number  <= cfg.data[7:0];
        lnef_pkg::REG_LEVEL:          regs.level          <= $signed(cfg.data);
        lnef_pkg::REG_SLOPE_DISTANCE: regs.slope_distance <= cfg.data[8:0];
        lnef_pkg::REG_BAND:           regs.band           <= $signed(cfg.data);
        lnef_pkg::REG_USE_MEAN:       regs.use_mean       <= cfg.data[0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ design/lnef_core.sv @@
// Load and search sequencer: fills the sample RAM, scans it, collects hits in the
// hit RAM and holds the result register. Depends on lnef_pkg.
`default_nettype none
module lnef_core #(
  parameter int LINE_LEN    = lnef_pkg::LINE_LEN_DEF,
  parameter int HIT_DEPTH   = lnef_pkg::HIT_DEPTH_DEF,
  parameter int MEAN_MARGIN = lnef_pkg::MEAN_MARGIN_DEF,
  localparam int XW  = $clog2(LINE_LEN),
  localparam int HAW = $clog2(HIT_DEPTH),
  localparam int SW  = lnef_pkg::VAL_W + lnef_pkg::RANK_W
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire lnef_pkg::cfg_t                      cfg,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [lnef_pkg::VAL_W-1:0]   in_value,
  input  wire logic [lnef_pkg::RANK_W-1:0]         in_rank,
  input  wire logic                                in_end,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [lnef_pkg::X_W-1:0]                 out_x,
  output logic signed [lnef_pkg::VAL_W-1:0]        out_value,
  output logic [lnef_pkg::RANK_W-1:0]              out_rank,
  output logic                                     smp_we,
  output logic [XW-1:0]                            smp_waddr,
  output logic [SW-1:0]                            smp_wdata,
  output logic [XW-1:0]                            smp_raddr,
  input  wire logic [SW-1:0]                       smp_rdata,
  output logic                                     hit_we,
  output logic [HAW-1:0]                           hit_waddr,
  output logic [XW-1:0]                            hit_wdata,
  output logic [HAW-1:0]                           hit_raddr,
  input  wire logic [XW-1:0]                       hit_rdata,
  output lnef_pkg::stat_t                          stat
);
  localparam int CW  = $clog2(LINE_LEN + 1);
  localparam int HCW = $clog2(HIT_DEPTH + 1);
  localparam int WW  = (CW > 10 ? CW : 10) + 1;
  localparam int PW  = (HCW > 8 ? HCW : 8) + 1;
  localparam int DW  = lnef_pkg::DEN_W;
  localparam logic [1:0] CLS_IN    = 2'd0;
  localparam logic [1:0] CLS_ABOVE = 2'd1;
  localparam logic [1:0] CLS_BELOW = 2'd2;

  lnef_pkg::state_t state, state_next;
  logic [CW-1:0] fill, fill_next, n, n_next, x, x_next;
  logic [CW-1:0] margin, margin_next, lim, lim_next, arm_x, arm_x_next;
  logic [DW-1:0] rem, rem_next, m, m_next, den, den_next;
  logic first, first_next, armed, armed_next;
  logic [1:0] cls, cls_next;
  logic [7:0] cnt, cnt_next;
  logic signed [lnef_pkg::SUM_W-1:0]  sum, sum_next;
  logic signed [lnef_pkg::PROD_W-1:0] prod, prod_next, vd, vd_next;
  logic signed [lnef_pkg::NUM_W-1:0]  num, num_next;
  logic signed [lnef_pkg::VAL_W-1:0]  v, v_next, p, p_next;
  logic [HCW-1:0] hits, hits_next;
  logic [XW-1:0] rx, rx_next;
  logic out_load;

  logic is_max, crossing, rd_valid, last_cr;
  logic [8:0] w;
  logic [CW-1:0] st_margin, d_cw;
  logic signed [lnef_pkg::VAL_W-1:0] rd_value;
  logic signed [33:0] diff, bnd, v34, p_hi, p_lo;
  logic [1:0] cls_new;
  logic arm, arm_eff, fire;
  logic [CW-1:0] arm_x_eff;
  logic [CW:0] mid;
  logic [PW-1:0] hw, ww, pos;

  assign is_max   = (cfg.search_mode == lnef_pkg::MODE_MAX);
  assign crossing = (cfg.search_mode == lnef_pkg::MODE_CROSS);
  assign w = (cfg.slope_distance > 9'(MEAN_MARGIN)) ? cfg.slope_distance : 9'(MEAN_MARGIN);
  assign d_cw = CW'(cfg.slope_distance);
  assign st_margin = cfg.use_mean ? CW'(w) : d_cw;
  assign rd_value = $signed(smp_rdata[SW-1:lnef_pkg::RANK_W]);
  assign rd_valid = (smp_rdata[lnef_pkg::RANK_W-1:0] != '0);
  assign last_cr  = cfg.from_right ? (x == '0) : (x == n - CW'(1));

  assign diff = 34'(rd_value) - 34'(cfg.level);
  assign bnd  = 34'(cfg.band);
  always_comb begin
    if (diff > bnd) begin
      cls_new = CLS_ABOVE;
    end else if (diff < -bnd) begin
      cls_new = CLS_BELOW;
    end else begin
      cls_new = CLS_IN;
    end
  end

  assign v34  = 34'(v);
  assign p_hi = 34'(p) + bnd;
  assign p_lo = 34'(p) - bnd;
  assign arm = is_max ? ((lnef_pkg::NUM_W'(vd) > num) && (v34 > p_hi))
                      : ((lnef_pkg::NUM_W'(vd) < num) && (v34 < p_lo));
  assign arm_eff   = arm | armed;
  assign arm_x_eff = arm ? x : arm_x;
  assign fire = arm_eff && (is_max ? (v34 < p_lo) : (v34 > p_hi));
  assign mid  = ((CW+1)'(x) + (CW+1)'(arm_x_eff)) >> 1;

  assign hw = PW'(hits);
  assign ww = PW'(cfg.wanted_number);
  always_comb begin
    if (!cfg.from_right) begin
      pos = (ww > hw) ? hw - PW'(1) : ww - PW'(1);
    end else begin
      pos = (ww >= hw) ? '0 : hw - ww;
    end
  end

  assign in_ready = (state == lnef_pkg::S_IDLE);
  assign stat.searching = (state != lnef_pkg::S_IDLE);
  assign stat.line_full = (fill == CW'(LINE_LEN));

  assign smp_we    = in_valid && in_ready && (fill < CW'(LINE_LEN));
  assign smp_waddr = fill[XW-1:0];
  assign smp_wdata = {in_value, in_rank};
  assign hit_waddr = hits[HAW-1:0];
  assign hit_wdata = mid[XW-1:0];
  assign hit_raddr = pos[HAW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lnef_pkg::S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    n <= n_next;       x <= x_next;         margin <= margin_next;
    lim <= lim_next;   arm_x <= arm_x_next; rem <= rem_next;
    m <= m_next;       den <= den_next;     first <= first_next;
    armed <= armed_next; cls <= cls_next;   cnt <= cnt_next;
    sum <= sum_next;   prod <= prod_next;   vd <= vd_next;
    num <= num_next;   v <= v_next;         p <= p_next;
    hits <= hits_next; rx <= rx_next;
    if (out_load) begin
      out_x     <= lnef_pkg::X_W'(rx);
      out_value <= rd_value;
      out_rank  <= smp_rdata[lnef_pkg::RANK_W-1:0];
    end
  end

  always_comb begin
    state_next = state;  fill_next = fill;   n_next = n;     x_next = x;
    margin_next = margin; lim_next = lim;    arm_x_next = arm_x;
    rem_next = rem;      m_next = m;         den_next = den;
    first_next = first;  armed_next = armed; cls_next = cls; cnt_next = cnt;
    sum_next = sum;      prod_next = prod;   vd_next = vd;   num_next = num;
    v_next = v;          p_next = p;         hits_next = hits; rx_next = rx;
    smp_raddr = x[XW-1:0];
    hit_we = 1'b0;
    out_load = 1'b0;
    case (state)
      lnef_pkg::S_IDLE: begin
        if (in_valid) begin
          if (smp_we) begin
            fill_next = fill + CW'(1);
          end
          if (in_end) begin
            n_next = smp_we ? fill + CW'(1) : fill;
            fill_next = '0;
            state_next = lnef_pkg::S_START;
          end
        end
      end
      lnef_pkg::S_START: begin
        rx_next = '0;
        hits_next = '0;
        armed_next = 1'b0;
        arm_x_next = '0;
        first_next = 1'b1;
        cls_next = CLS_IN;
        cnt_next = '0;
        margin_next = st_margin;
        lim_next = n - st_margin;
        sum_next = '0;
        m_next = '0;
        if (crossing) begin
          x_next = cfg.from_right ? n - CW'(2) : CW'(1);
          smp_raddr = x_next[XW-1:0];
          if (cfg.wanted_number == '0 || n < CW'(2)) begin
            state_next = lnef_pkg::S_FETCH;
          end else begin
            state_next = lnef_pkg::S_CR;
          end
        end else if (cfg.wanted_number == '0 || WW'(n) < WW'(w) + WW'(2)) begin
          state_next = lnef_pkg::S_FETCH;
        end else if (cfg.use_mean) begin
          x_next = cfg.from_right ? n - CW'(1) : CW'(1);
          rem_next = cfg.from_right ? DW'(w) - DW'(1) : DW'(w) + DW'(1);
          smp_raddr = x_next[XW-1:0];
          if (cfg.from_right ? (WW'(n) - WW'(1) <= WW'(w))
                             : (CW'(1) >= n - st_margin)) begin
            state_next = lnef_pkg::S_FETCH;
          end else begin
            state_next = lnef_pkg::S_MF;
          end
        end else begin
          den_next = DW'(1);
          num_next = lnef_pkg::NUM_W'(cfg.level);
          x_next = st_margin;
          smp_raddr = x_next[XW-1:0];
          state_next = (st_margin >= n - st_margin) ? lnef_pkg::S_SEL : lnef_pkg::S_SV;
        end
      end
      lnef_pkg::S_CR: begin
        if (rd_valid) begin
          cls_next = cls_new;
          first_next = 1'b0;
        end
        if (rd_valid && !first && cls_new != cls && cnt + 8'd1 == cfg.wanted_number) begin
          rx_next = x[XW-1:0];
          state_next = lnef_pkg::S_FETCH;
        end else begin
          if (rd_valid && !first && cls_new != cls) begin
            cnt_next = cnt + 8'd1;
          end
          if (last_cr) begin
            state_next = lnef_pkg::S_FETCH;
          end else begin
            x_next = cfg.from_right ? x - CW'(1) : x + CW'(1);
            smp_raddr = x_next[XW-1:0];
          end
        end
      end
      lnef_pkg::S_MF: begin
        if (rd_valid) begin
          state_next = lnef_pkg::S_MS;
        end else begin
          x_next = cfg.from_right ? x - CW'(1) : x + CW'(1);
          smp_raddr = x_next[XW-1:0];
          if (cfg.from_right ? (x_next <= margin) : (x_next >= lim)) begin
            state_next = lnef_pkg::S_FETCH;
          end
        end
      end
      lnef_pkg::S_MS: begin
        if (rd_valid) begin
          sum_next = sum + lnef_pkg::SUM_W'(rd_value);
          m_next = m + DW'(1);
        end
        if (rem == DW'(1)) begin
          state_next = lnef_pkg::S_MUL;
        end else begin
          rem_next = rem - DW'(1);
          x_next = cfg.from_right ? x - CW'(1) : x + CW'(1);
          smp_raddr = x_next[XW-1:0];
        end
      end
      lnef_pkg::S_MUL: begin
        prod_next = lnef_pkg::PROD_W'(cfg.level) * lnef_pkg::PROD_W'($signed({1'b0, m}));
        den_next = m;
        state_next = (m <= DW'(lnef_pkg::MIN_MEAN_COUNT)) ? lnef_pkg::S_FETCH
                                                           : lnef_pkg::S_NUM;
      end
      lnef_pkg::S_NUM: begin
        num_next = is_max ? lnef_pkg::NUM_W'(sum) + lnef_pkg::NUM_W'(prod)
                          : lnef_pkg::NUM_W'(sum) - lnef_pkg::NUM_W'(prod);
        x_next = margin;
        smp_raddr = x_next[XW-1:0];
        state_next = (margin >= lim) ? lnef_pkg::S_SEL : lnef_pkg::S_SV;
      end
      lnef_pkg::S_SV: begin
        if (rd_valid) begin
          v_next = rd_value;
          smp_raddr = XW'(x - d_cw);
          state_next = lnef_pkg::S_SP;
        end else begin
          x_next = x + CW'(1);
          smp_raddr = x_next[XW-1:0];
          if (x_next >= lim) begin
            state_next = lnef_pkg::S_SEL;
          end
        end
      end
      lnef_pkg::S_SP: begin
        p_next = rd_value;
        vd_next = lnef_pkg::PROD_W'(v) * lnef_pkg::PROD_W'($signed({1'b0, den}));
        state_next = lnef_pkg::S_SE;
      end
      lnef_pkg::S_SE: begin
        armed_next = arm_eff;
        arm_x_next = arm_x_eff;
        if (fire) begin
          armed_next = 1'b0;
          arm_x_next = mid[CW-1:0];
          if (hits < HCW'(HIT_DEPTH)) begin
            hit_we = 1'b1;
            hits_next = hits + HCW'(1);
          end
        end
        x_next = x + CW'(1);
        smp_raddr = x_next[XW-1:0];
        state_next = (x_next >= lim) ? lnef_pkg::S_SEL : lnef_pkg::S_SV;
      end
      lnef_pkg::S_SEL: begin
        state_next = (hits == '0) ? lnef_pkg::S_FETCH : lnef_pkg::S_HW;
      end
      lnef_pkg::S_HW: begin
        rx_next = hit_rdata;
        state_next = lnef_pkg::S_FETCH;
      end
      lnef_pkg::S_FETCH: begin
        smp_raddr = rx;
        state_next = lnef_pkg::S_OUT;
      end
      lnef_pkg::S_OUT: begin
        smp_raddr = rx;
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          state_next = lnef_pkg::S_IDLE;
        end
      end
      default: state_next = lnef_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ design/line_nth_extremum_finder.sv @@
// Top level of the line nth extremum finder: config registers, sequencer, RAMs.
// Depends on lnef_pkg, lnef_if, lnef_ram, lnef_cfg_regs and lnef_core.
//
// Usage: samples of one profile line enter on the samples channel, one item per
// cycle while ready is high, and are written to the sample RAM. An item with
// line_end set closes the line; ready then stays low while the line is searched.
// Each line gives exactly one item on the results channel.
// Search steps after line_end: a start step, then in crossing mode a scan of the
// samples and a fetch of the stored sample. Peak modes with the mean: a skip of
// invalid samples ahead of the window, a sum over the window samples and the
// forming of the threshold; then a scan in which each valid sample is read at x,
// read at x minus slope distance, multiplied and compared, and last the pick of
// the hit and the fetch of the stored sample. Lines with no search (too short,
// wanted number zero) take the start and fetch steps only.
// The result waits in an output register. The next line may load meanwhile; its
// search then holds in its last state, with ready low, until the result is taken.
// Reset clears the configuration to its defaults, the fill count and the output
// valid; RAM contents are not cleared. The cfg channel is always ready and may be
// written only while no line is being searched.
`default_nettype none
module line_nth_extremum_finder #(
  parameter int LINE_LEN    = lnef_pkg::LINE_LEN_DEF,
  parameter int HIT_DEPTH   = lnef_pkg::HIT_DEPTH_DEF,
  parameter int MEAN_MARGIN = lnef_pkg::MEAN_MARGIN_DEF
) (
  input wire logic       clk,
  input wire logic       rst,
  lnef_sample_if.sink    samples,
  lnef_result_if.source  results,
  lnef_cfg_if.sink       cfg
);
  localparam int XW  = $clog2(LINE_LEN);
  localparam int HAW = $clog2(HIT_DEPTH);
  localparam int SW  = lnef_pkg::VAL_W + lnef_pkg::RANK_W;

  lnef_pkg::cfg_t  regs;
  lnef_pkg::stat_t stat;
  logic            smp_we, hit_we;
  logic [XW-1:0]   smp_waddr, smp_raddr, hit_wdata, hit_rdata;
  logic [SW-1:0]   smp_wdata, smp_rdata;
  logic [HAW-1:0]  hit_waddr, hit_raddr;

  lnef_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  lnef_ram #(.WIDTH(SW), .DEPTH(LINE_LEN)) u_sample_ram (
    .clk   (clk),
    .we    (smp_we),
    .waddr (smp_waddr),
    .wdata (smp_wdata),
    .raddr (smp_raddr),
    .rdata (smp_rdata)
  );

  lnef_ram #(.WIDTH(XW), .DEPTH(HIT_DEPTH)) u_hit_ram (
    .clk   (clk),
    .we    (hit_we),
    .waddr (hit_waddr),
    .wdata (hit_wdata),
    .raddr (hit_raddr),
    .rdata (hit_rdata)
  );

  lnef_core #(
    .LINE_LEN    (LINE_LEN),
    .HIT_DEPTH   (HIT_DEPTH),
    .MEAN_MARGIN (MEAN_MARGIN)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (regs),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .in_value  (samples.sample_value),
    .in_rank   (samples.sample_rank),
    .in_end    (samples.line_end),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_x     (results.found_x),
    .out_value (results.found_value),
    .out_rank  (results.found_rank),
    .smp_we    (smp_we),
    .smp_waddr (smp_waddr),
    .smp_wdata (smp_wdata),
    .smp_raddr (smp_raddr),
    .smp_rdata (smp_rdata),
    .hit_we    (hit_we),
    .hit_waddr (hit_waddr),
    .hit_wdata (hit_wdata),
    .hit_raddr (hit_raddr),
    .hit_rdata (hit_rdata),
    .stat      (stat)
  );

  a_end_starts_search: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready && samples.line_end |=> stat.searching && !stat.line_full)
    else $error("line end did not start a search");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    stat.line_full && samples.valid && samples.ready && !samples.line_end |=> stat.line_full)
    else $error("full line count changed on overflow item");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> !$rose(results.valid))
    else $error("result raised right after a load item");

endmodule
`default_nettype wire
